// File: rtl/lja_pkg.sv
// Package for the LCG jump-ahead core: generator constants, the per-stage item
// record, and elaboration-time functions for the squared multipliers and offsets.
// No dependencies.
package lja_pkg;

  localparam int unsigned SEED_W  = 32;
  localparam int unsigned STEPS_W = 32;
  localparam int unsigned HALF_W  = 16;

  localparam logic [SEED_W-1:0] LCG_MUL = 32'h0003_43FD;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'h0026_9EC3;

  // One item in flight: the seed, the step bits not yet consumed (bit 0 is the
  // next one), and the running affine map acc_mul * x + acc_add.
  typedef struct packed {
    logic [SEED_W-1:0]  seed;
    logic [STEPS_W-1:0] steps;
    logic [SEED_W-1:0]  acc_mul;
    logic [SEED_W-1:0]  acc_add;
  } lja_item_t;

  // Multiplier of 2^k generator steps: LCG_MUL squared k times.
  function automatic logic [SEED_W-1:0] lcg_mul_pow(input int unsigned k);
    logic [SEED_W-1:0]   m;
    logic [2*SEED_W-1:0] p;
    m = LCG_MUL;
    for (int unsigned i = 0; i < k; i++) begin
      p = m * m;
      m = p[SEED_W-1:0];
    end
    return m;
  endfunction

  // Offset of 2^k generator steps, built by the doubling rule c <- (m + 1) * c.
  function automatic logic [SEED_W-1:0] lcg_add_pow(input int unsigned k);
    logic [SEED_W-1:0]   m;
    logic [SEED_W-1:0]   c;
    logic [2*SEED_W-1:0] p;
    m = LCG_MUL;
    c = LCG_ADD;
    for (int unsigned i = 0; i < k; i++) begin
      p = (m + SEED_W'(1)) * c;
      c = p[SEED_W-1:0];
      p = m * m;
      m = p[SEED_W-1:0];
    end
    return c;
  endfunction

endpackage

// File: rtl/lja_stage.sv
// One exponent-bit stage of the LCG jump-ahead pipeline.
// Depends on lja_pkg for the item record.
module lja_stage
  import lja_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  lja_item_t         in_item,
  input  logic [SEED_W-1:0] cur_mul,
  input  logic [SEED_W-1:0] cur_add,
  output logic              out_valid,
  output lja_item_t         out_item
);

  logic                valid_r;
  lja_item_t           item_r;
  lja_item_t           item_nxt;
  logic [2*SEED_W-1:0] mul_prod;
  logic [2*SEED_W-1:0] add_prod;

  // When the current step bit is set, compose the 2^k-step map onto the
  // running map; the step word then shifts so the next stage sees its bit at 0.
  always_comb begin
    mul_prod = in_item.acc_mul * cur_mul;
    add_prod = in_item.acc_add * cur_mul;
    item_nxt = in_item;
    item_nxt.steps = in_item.steps >> 1;
    if (in_item.steps[0]) begin
      item_nxt.acc_mul = mul_prod[SEED_W-1:0];
      item_nxt.acc_add = add_prod[SEED_W-1:0] + cur_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// File: rtl/lja_apply.sv
// Final stage of the LCG jump-ahead pipeline: applies the accumulated map to
// the seed and holds the result for the output channel. Depends on lja_pkg.
module lja_apply
  import lja_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  lja_item_t         in_item,
  output logic              out_valid,
  output logic [SEED_W-1:0] out_seed
);

  logic                valid_r;
  logic [SEED_W-1:0]   seed_r;
  logic [SEED_W-1:0]   seed_nxt;
  logic [2*SEED_W-1:0] prod;

  always_comb begin
    prod     = in_item.acc_mul * in_item.seed;
    seed_nxt = prod[SEED_W-1:0] + in_item.acc_add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seed_r <= seed_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_seed  = seed_r;

endmodule

// File: rtl/lcg_jump_ahead_core.sv
// LCG jump-ahead core for the generator x <- x * 0x343FD + 0x269EC3 (mod 2^32).
//
// Usage: present a seed and a step count on the input stream (in_tdata) and
// the core returns the seed advanced by that many generator steps, together
// with the upper 16 bits of that state, on the output stream (out_tdata).
// A step count of zero returns the seed unchanged.
//
// Pipeline: the item passes 33 register stages: 32 stages, one per bit of the
// step count, each composing a fixed 2^k-step map (the first loads at the
// accepting edge), and one final stage that applies the map to the seed and
// doubles as the output register; out_tvalid rises when that register loads.
// Throughput is one item per cycle while the receiver does not stall; each
// stage holds two 32x32 constant multipliers, which set the clock period.
//
// Reset (rst_n low, synchronous) clears every stage's valid bit; items in
// flight are dropped and the core is ready again on the next cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready drops; no item is lost or repeated. Bubbles ahead of a stall
// are not squeezed out.
module lcg_jump_ahead_core
  import lja_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] start_seed, [63:32] step_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] advanced_seed, [47:32] upper_half
);

  localparam int unsigned NUM_STAGES = STEPS_W;

  logic              adv;
  logic              stage_valid [0:NUM_STAGES];
  lja_item_t         stage_item  [0:NUM_STAGES];
  logic [SEED_W-1:0] result_seed;

  // The pipeline moves as a whole whenever the output register is free or
  // being drained this cycle.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // A new item starts from the identity map.
  always_comb begin
    stage_valid[0]        = in_tvalid;
    stage_item[0].seed    = in_tdata[SEED_W-1:0];
    stage_item[0].steps   = in_tdata[SEED_W +: STEPS_W];
    stage_item[0].acc_mul = SEED_W'(1);
    stage_item[0].acc_add = '0;
  end

  // Stage k consumes step bit k using the constant map of 2^k steps.
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam logic [SEED_W-1:0] CurMul = lcg_mul_pow(k);
    localparam logic [SEED_W-1:0] CurAdd = lcg_add_pow(k);

    lja_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (stage_valid[k]),
      .in_item   (stage_item[k]),
      .cur_mul   (CurMul),
      .cur_add   (CurAdd),
      .out_valid (stage_valid[k+1]),
      .out_item  (stage_item[k+1])
    );
  end

  lja_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (stage_valid[NUM_STAGES]),
    .in_item   (stage_item[NUM_STAGES]),
    .out_valid (out_tvalid),
    .out_seed  (result_seed)
  );

  // The upper half is simply the top bits of the advanced state.
  assign out_tdata = {result_seed[SEED_W-1 -: HALF_W], result_seed};

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for lcg_jump_ahead_core: it streams seed and step-count
// items through the core and compares each result against a square-and-multiply
// predictor. Depends on lja_pkg and lcg_jump_ahead_core.
module tb_top;
  import lja_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned IDLE_PCT     = 17;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  // Keeps the predicted states in arrival order and checks each result.
  class jump_scoreboard;
    typedef struct {
      logic [SEED_W-1:0] state;
      logic [HALF_W-1:0] upper;
    } jump_result_t;

    jump_result_t expected_q[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // The affine map of 2^k steps is composed into the running map for every
    // set bit of the step count; the running map starts as the identity.
    function automatic logic [SEED_W-1:0] skip_ahead(logic [SEED_W-1:0] seed,
                                                     logic [STEPS_W-1:0] steps);
      logic [SEED_W-1:0] acc_mul;
      logic [SEED_W-1:0] acc_add;
      logic [SEED_W-1:0] pow_mul;
      logic [SEED_W-1:0] pow_add;
      acc_mul = 32'd1;
      acc_add = 32'd0;
      pow_mul = LCG_MUL;
      pow_add = LCG_ADD;
      for (int b = 0; b < STEPS_W; b++) begin
        if (steps[b]) begin
          acc_mul = acc_mul * pow_mul;
          acc_add = acc_add * pow_mul + pow_add;
        end
        pow_add = (pow_mul + 32'd1) * pow_add;
        pow_mul = pow_mul * pow_mul;
      end
      return acc_mul * seed + acc_add;
    endfunction

    function void note_request(logic [SEED_W-1:0] seed, logic [STEPS_W-1:0] steps);
      jump_result_t r;
      r.state = skip_ahead(seed, steps);
      r.upper = r.state[SEED_W-1:SEED_W-HALF_W];
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [47:0] data);
      jump_result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: advanced_seed expected none, actual %h", data[31:0]);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (data[31:0] !== r.state) begin
        $error("advanced_seed mismatch: expected %h, actual %h", r.state, data[31:0]);
        errors++;
      end
      if (data[47:32] !== r.upper) begin
        $error("upper_half mismatch: expected %h, actual %h", r.upper, data[47:32]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  jump_scoreboard sb = new();
  bit             calm = 1'b0;  // while set, neither side idles
  int unsigned    cycles = 0;

  lcg_jump_ahead_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshakes are sampled at the edge, before any nonblocking update lands.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tdata[31:0], in_tdata[63:32]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rst_n)
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] seed, input logic [31:0] steps);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {steps, seed};
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the sender off until the pipeline has handed back every result.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_steps();
    logic [31:0] s;
    case ($urandom_range(0, 3))
      0:       s = $urandom();
      1:       s = $urandom_range(0, 64);
      2:       s = 32'd1 << $urandom_range(0, 31);
      default: s = ~(32'd1 << $urandom_range(0, 31));
    endcase
    return s;
  endfunction

  initial begin
    logic [31:0] dir_seed[$];
    logic [31:0] dir_steps[$];
    dir_seed  = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF,
                  32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'hDEAD_BEEF, 32'h0000_FFFF, 32'hFFFF_0000,
                  32'h0BAD_F00D, 32'h0000_0001, 32'h7FFF_FFFF, 32'hCAFE_0001};
    dir_steps = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h1,
                  32'h2, 32'h3, 32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0001_0000,
                  32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0010, 32'h8000_0001};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes and the zero-step pass-through.
    foreach (dir_seed[i])
      send_item(dir_seed[i], dir_steps[i]);
    drain();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 250 && n < 400);
      if (n == 500)
        drain();
      send_item($urandom(), random_steps());
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
